### hw/rtl/brp_pkg.sv
`default_nettype none
package brp_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int FIELD_W         = 64;
    localparam int CFG_W           = 64;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

    // phase: 0..5 position in the prefix, then parsing, then discarding
    localparam int PREFIX_LEN = 6;
    localparam logic [2:0] PH_PARSE   = 3'd6;
    localparam logic [2:0] PH_DISCARD = 3'd7;

    localparam logic [7:0] PREFIX_TEXT [0:PREFIX_LEN-1] =
        '{8'h62, 8'h79, 8'h74, 8'h65, 8'h73, 8'h3d};   // "bytes="

    typedef enum logic [2:0] {
        PS_INIT  = 3'd0,
        PS_START = 3'd1,
        PS_GAP1  = 3'd2,
        PS_GAP2  = 3'd3,
        PS_STOP  = 3'd4
    } pstate_t;

    typedef enum logic [2:0] {
        ACT_NONE             = 3'd0,
        ACT_PUSH_START       = 3'd1,
        ACT_PUSH_STOP        = 3'd2,
        ACT_OMIT_START       = 3'd3,
        ACT_OMIT_STOP_SUBMIT = 3'd4,
        ACT_SUBMIT           = 3'd5,
        ACT_ABORT            = 3'd6
    } act_t;

    typedef enum logic [2:0] {
        CL_DIGIT  = 3'd0,
        CL_WHITE  = 3'd1,
        CL_COMMA  = 3'd2,
        CL_HYPHEN = 3'd3,
        CL_END    = 3'd4,
        CL_OTHER  = 3'd5
    } class_t;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_BAD_PREFIX = 2'd1,
        STS_BAD_SYNTAX = 2'd2,
        STS_NO_RANGE   = 2'd3
    } status_t;

    typedef enum logic {
        KIND_RANGE  = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        act_t    act;
        pstate_t nxt;
    } step_t;

    typedef struct packed {
        kind_t              kind;
        logic [FIELD_W-1:0] range_start;
        logic [FIELD_W-1:0] range_stop;
        status_t            status;
        logic               last;
    } result_t;

    // up to two results per header byte: a range, then the status
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic class_t classify(input logic [7:0] c);
        class_t cl;
        if (c inside {[8'h30:8'h39]}) begin
            cl = CL_DIGIT;
        end else if (c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d}) begin
            cl = CL_WHITE;
        end else if (c == 8'h2c) begin
            cl = CL_COMMA;
        end else if (c == 8'h2d) begin
            cl = CL_HYPHEN;
        end else if (c == 8'h00) begin
            cl = CL_END;
        end else begin
            cl = CL_OTHER;
        end
        return cl;
    endfunction

    function automatic step_t step_lookup(input pstate_t st, input class_t cl);
        step_t s;
        s = '{act: ACT_ABORT, nxt: PS_INIT};
        case (st)
            PS_INIT: begin
                case (cl)
                    CL_DIGIT:  s = '{act: ACT_PUSH_START, nxt: PS_START};
                    CL_WHITE:  s = '{act: ACT_NONE, nxt: PS_INIT};
                    CL_COMMA:  s = '{act: ACT_NONE, nxt: PS_INIT};
                    CL_HYPHEN: s = '{act: ACT_OMIT_START, nxt: PS_GAP2};
                    CL_END:    s = '{act: ACT_NONE, nxt: PS_INIT};
                    default:   s = '{act: ACT_ABORT, nxt: PS_INIT};
                endcase
            end
            PS_START: begin
                case (cl)
                    CL_DIGIT:  s = '{act: ACT_PUSH_START, nxt: PS_START};
                    CL_WHITE:  s = '{act: ACT_NONE, nxt: PS_GAP1};
                    CL_HYPHEN: s = '{act: ACT_NONE, nxt: PS_GAP2};
                    default:   s = '{act: ACT_ABORT, nxt: PS_INIT};
                endcase
            end
            PS_GAP1: begin
                case (cl)
                    CL_WHITE:  s = '{act: ACT_NONE, nxt: PS_GAP1};
                    CL_HYPHEN: s = '{act: ACT_NONE, nxt: PS_GAP2};
                    default:   s = '{act: ACT_ABORT, nxt: PS_INIT};
                endcase
            end
            PS_GAP2: begin
                case (cl)
                    CL_DIGIT:  s = '{act: ACT_PUSH_STOP, nxt: PS_STOP};
                    CL_WHITE:  s = '{act: ACT_NONE, nxt: PS_GAP2};
                    CL_COMMA:  s = '{act: ACT_OMIT_STOP_SUBMIT, nxt: PS_INIT};
                    CL_END:    s = '{act: ACT_OMIT_STOP_SUBMIT, nxt: PS_INIT};
                    default:   s = '{act: ACT_ABORT, nxt: PS_INIT};
                endcase
            end
            PS_STOP: begin
                case (cl)
                    CL_DIGIT:  s = '{act: ACT_PUSH_STOP, nxt: PS_STOP};
                    CL_WHITE:  s = '{act: ACT_SUBMIT, nxt: PS_INIT};
                    CL_COMMA:  s = '{act: ACT_SUBMIT, nxt: PS_INIT};
                    CL_END:    s = '{act: ACT_SUBMIT, nxt: PS_INIT};
                    default:   s = '{act: ACT_ABORT, nxt: PS_INIT};
                endcase
            end
            default: s = '{act: ACT_ABORT, nxt: PS_INIT};
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/brp_parser.sv
`default_nettype none
module brp_parser
    import brp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire logic             in_valid,
    input  wire logic [7:0]       in_byte,
    output logic                  in_ready,
    input  wire logic             room,
    output push_t                 push
);

    localparam logic [VALUE_WIDTH-1:0] ONES = '1;

    logic [VALUE_WIDTH-1:0] fsize_reg;
    logic                   byte_valid_reg, byte_valid_next;
    logic [7:0]             byte_reg, byte_next;

    logic [2:0]             phase_reg, phase_next;
    pstate_t                pstate_reg, pstate_next;
    status_t                err_reg, err_next;
    logic [VALUE_WIDTH-1:0] start_reg, start_next;
    logic [VALUE_WIDTH-1:0] stop_reg, stop_next;
    logic                   any_valid_reg, any_valid_next;

    logic                   fire;
    logic                   is_end;
    logic                   in_prefix;
    logic [7:0]             lc;
    class_t                 cls;
    step_t                  ent;
    logic [VALUE_WIDTH-1:0] digit;
    logic [VALUE_WIDTH-1:0] start_acc;
    logic [VALUE_WIDTH-1:0] stop_acc;
    logic                   submit;
    logic [VALUE_WIDTH-1:0] a_val, b_val;
    logic                   res_ok;
    logic [VALUE_WIDTH-1:0] res_s, res_e;
    logic [VALUE_WIDTH-1:0] fs_m1;
    result_t                rng_res, sts_res;

    assign fire     = byte_valid_reg && room;
    assign in_ready = !byte_valid_reg || room;

    always_comb begin
        byte_valid_next = byte_valid_reg;
        byte_next       = byte_reg;
        if (in_ready) begin
            byte_valid_next = in_valid;
            byte_next       = in_byte;
        end
    end

    // decode of the held byte
    always_comb begin
        is_end    = (byte_reg == 8'h00);
        in_prefix = (phase_reg < PH_PARSE);
        lc        = (byte_reg inside {[8'h41:8'h5a]}) ? (byte_reg + 8'h20) : byte_reg;
        cls       = classify(byte_reg);
        ent       = step_lookup(pstate_reg, cls);
        digit     = VALUE_WIDTH'(byte_reg[3:0]);
        // times ten as two shifts and an add, modulo 2^VALUE_WIDTH
        start_acc = (start_reg << 3) + (start_reg << 1) + digit;
        stop_acc  = (stop_reg << 3) + (stop_reg << 1) + digit;
        submit    = (ent.act == ACT_SUBMIT) || (ent.act == ACT_OMIT_STOP_SUBMIT);
        a_val     = start_reg;
        b_val     = (ent.act == ACT_OMIT_STOP_SUBMIT) ? ONES : stop_reg;
    end

    // range resolution, all compares side by side
    always_comb begin
        fs_m1  = fsize_reg - VALUE_WIDTH'(1);
        res_ok = 1'b0;
        res_s  = a_val;
        res_e  = fs_m1;
        if (fsize_reg != '0) begin
            if (a_val == ONES) begin
                // suffix range
                res_ok = (b_val != ONES) && (b_val != '0);
                res_s  = (b_val > fsize_reg) ? '0 : (fsize_reg - b_val);
                res_e  = fs_m1;
            end else if (b_val == ONES) begin
                res_ok = (a_val < fsize_reg);
                res_e  = fs_m1;
            end else begin
                res_ok = (a_val <= b_val) && (a_val < fsize_reg);
                res_e  = (b_val >= fsize_reg) ? fs_m1 : b_val;
            end
        end
    end

    // next state
    always_comb begin
        phase_next     = phase_reg;
        pstate_next    = pstate_reg;
        err_next       = err_reg;
        start_next     = start_reg;
        stop_next      = stop_reg;
        any_valid_next = any_valid_reg;
        if (fire) begin
            if (in_prefix) begin
                if (is_end) begin
                    phase_next = '0;
                end else if (lc == PREFIX_TEXT[phase_reg]) begin
                    phase_next = phase_reg + 3'd1;
                end else begin
                    phase_next = PH_DISCARD;
                    err_next   = STS_BAD_PREFIX;
                end
            end else if (phase_reg == PH_DISCARD) begin
                if (is_end) begin
                    phase_next = '0;
                end
            end else begin
                case (ent.act)
                    ACT_PUSH_START: start_next = start_acc;
                    ACT_PUSH_STOP:  stop_next  = stop_acc;
                    ACT_OMIT_START: start_next = ONES;
                    default: ;
                endcase
                if (ent.act == ACT_ABORT) begin
                    if (is_end) begin
                        phase_next = '0;
                    end else begin
                        phase_next = PH_DISCARD;
                        err_next   = STS_BAD_SYNTAX;
                    end
                end else begin
                    if (submit) begin
                        start_next = '0;
                        stop_next  = '0;
                        if (res_ok) begin
                            any_valid_next = 1'b1;
                        end
                    end
                    if (is_end) begin
                        phase_next = '0;
                    end else begin
                        pstate_next = ent.nxt;
                    end
                end
            end
            // end byte always starts a fresh header
            if (is_end) begin
                pstate_next    = PS_INIT;
                start_next     = '0;
                stop_next      = '0;
                any_valid_next = 1'b0;
            end
        end
    end

    // results
    always_comb begin
        rng_res             = '0;
        rng_res.kind        = KIND_RANGE;
        rng_res.range_start = FIELD_W'(res_s);
        rng_res.range_stop  = FIELD_W'(res_e);
        rng_res.status      = STS_OK;
        sts_res             = '0;
        sts_res.kind        = KIND_STATUS;
        sts_res.last        = 1'b1;
        sts_res.status      = STS_OK;
        push                = '0;
        if (fire && is_end) begin
            if (in_prefix) begin
                sts_res.status = STS_BAD_PREFIX;
            end else if (phase_reg == PH_DISCARD) begin
                sts_res.status = err_reg;
            end else if (ent.act == ACT_ABORT) begin
                sts_res.status = STS_BAD_SYNTAX;
            end else if (!(any_valid_reg || (submit && res_ok))) begin
                sts_res.status = STS_NO_RANGE;
            end
        end
        if (fire) begin
            if (!in_prefix && phase_reg != PH_DISCARD && submit && res_ok) begin
                rng_res.last = !is_end;
                push.r0      = rng_res;
                push.cnt     = 2'd1;
                if (is_end) begin
                    push.r1  = sts_res;
                    push.cnt = 2'd2;
                end
            end else if (is_end) begin
                push.r0  = sts_res;
                push.cnt = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsize_reg      <= '0;
            byte_valid_reg <= 1'b0;
            phase_reg      <= '0;
            pstate_reg     <= PS_INIT;
            err_reg        <= STS_OK;
            start_reg      <= '0;
            stop_reg       <= '0;
            any_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fsize_reg <= cfg_wr_data[VALUE_WIDTH-1:0];
            end
            byte_valid_reg <= byte_valid_next;
            phase_reg      <= phase_next;
            pstate_reg     <= pstate_next;
            err_reg        <= err_next;
            start_reg      <= start_next;
            stop_reg       <= stop_next;
            any_valid_reg  <= any_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule
`default_nettype wire

### hw/rtl/brp_result_fifo.sv
`default_nettype none
module brp_result_fifo
    import brp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_res
);

    result_t               mem [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;
    logic [FIFO_PTR_W-1:0] wr_ptr_p1;

    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a worst-case beat pair, judged before this cycle's pop
    assign room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.cnt);
        rd_ptr_next = pop ? (rd_ptr_reg + FIFO_PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_p1] <= push.r1;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/http_byte_range_parser.sv
// path: a header byte is registered, then its results are written into the result queue
// throughput: one header byte per cycle while the queue has room; a byte that closes
//   a range and ends the header yields two result beats, which the four-entry queue absorbs
// reset: aresetn low at a rising edge clears file_size to 0, the prefix/parse state
//   and the result queue
`default_nettype none
module http_byte_range_parser
    import brp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,   // file_size
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,       // header_byte
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [135:0]          m_tdata,       // range_start, range_stop, status, zero pad
    output logic                  m_tuser,       // kind
    output logic                  m_tlast
);

    push_t   push;
    logic    room;
    result_t res;

    brp_parser #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_ready   (s_tready),
        .room       (room),
        .push       (push)
    );

    brp_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (res)
    );

    assign m_tdata = {6'd0, res.status, res.range_stop, res.range_start};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
`default_nettype wire

### hw/rtl/brp_checker.sv
`default_nettype none
module brp_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata,
    input wire logic         m_tuser,
    input wire logic         m_tlast
);

    // a stalled beat stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a range beat that is not last is followed right away by its status beat
    a_range_then_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser && !m_tlast |=> m_tvalid && m_tuser)
        else $error("status beat missing after range");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("status beat not marked last");

    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[63:0] <= m_tdata[127:64]))
        else $error("range start beyond stop");

    a_range_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[129:128] == 2'd0))
        else $error("range beat carries a status code");

endmodule

bind http_byte_range_parser brp_checker u_brp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
`default_nettype wire

### tb/tb_http_byte_range_parser.sv
module tb_http_byte_range_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import brp_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int PHASE_BYTES = 250;
    localparam int HOLD_CYCLES = 300;

    class range_scoreboard;
        logic [63:0] file_size;
        logic [2:0]  phase;
        pstate_t     pst;
        status_t     discard_sts;
        logic [63:0] start_num;
        logic [63:0] stop_num;
        bit          any_valid;
        string       unit_text;
        result_t     pending_results[$];
        int          errors;

        function new();
            file_size = '0;
            unit_text = "bytes=";
            errors    = 0;
            clear_header();
        endfunction

        function void clear_header();
            phase       = '0;
            pst         = PS_INIT;
            discard_sts = STS_OK;
            start_num   = '0;
            stop_num    = '0;
            any_valid   = 1'b0;
        endfunction

        function class_t char_class(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return CL_DIGIT;
            if (c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d}) return CL_WHITE;
            if (c == 8'h2c) return CL_COMMA;
            if (c == 8'h2d) return CL_HYPHEN;
            if (c == 8'h00) return CL_END;
            return CL_OTHER;
        endfunction

        function step_t parse_step(pstate_t st, class_t cl);
            step_t s;
            s = '{ACT_ABORT, PS_INIT};
            case (st)
                PS_INIT: begin
                    case (cl)
                        CL_DIGIT:                s = '{ACT_PUSH_START, PS_START};
                        CL_WHITE, CL_COMMA, CL_END: s = '{ACT_NONE, PS_INIT};
                        CL_HYPHEN:               s = '{ACT_OMIT_START, PS_GAP2};
                        default: ;
                    endcase
                end
                PS_START: begin
                    case (cl)
                        CL_DIGIT:  s = '{ACT_PUSH_START, PS_START};
                        CL_WHITE:  s = '{ACT_NONE, PS_GAP1};
                        CL_HYPHEN: s = '{ACT_NONE, PS_GAP2};
                        default: ;
                    endcase
                end
                PS_GAP1: begin
                    case (cl)
                        CL_WHITE:  s = '{ACT_NONE, PS_GAP1};
                        CL_HYPHEN: s = '{ACT_NONE, PS_GAP2};
                        default: ;
                    endcase
                end
                PS_GAP2: begin
                    case (cl)
                        CL_DIGIT:        s = '{ACT_PUSH_STOP, PS_STOP};
                        CL_WHITE:        s = '{ACT_NONE, PS_GAP2};
                        CL_COMMA, CL_END: s = '{ACT_OMIT_STOP_SUBMIT, PS_INIT};
                        default: ;
                    endcase
                end
                PS_STOP: begin
                    case (cl)
                        CL_DIGIT:                   s = '{ACT_PUSH_STOP, PS_STOP};
                        CL_WHITE, CL_COMMA, CL_END: s = '{ACT_SUBMIT, PS_INIT};
                        default: ;
                    endcase
                end
                default: ;
            endcase
            return s;
        endfunction

        // all ones in either number means it was left out
        function bit resolve_range(output logic [63:0] first, output logic [63:0] lastb);
            logic [63:0] a;
            logic [63:0] b;
            a = start_num;
            b = stop_num;
            first = '0;
            lastb = '0;
            if (file_size == '0) return 0;
            if (a == '1) begin
                if (b == '1 || b == '0) return 0;
                a = (b > file_size) ? 64'd0 : file_size - b;
                b = file_size - 1;
            end else if (b == '1) begin
                b = file_size - 1;
            end else if (a > b) begin
                return 0;
            end
            if (a >= file_size) return 0;
            if (b > file_size - 1) b = file_size - 1;
            first = a;
            lastb = b;
            return 1;
        endfunction

        function result_t status_beat(status_t sts);
            result_t r;
            r = '0;
            r.kind   = KIND_STATUS;
            r.status = sts;
            return r;
        endfunction

        function void note_byte(logic [7:0] c);
            result_t     outs[2];
            int          n;
            logic [7:0]  lc;
            class_t      cl;
            step_t       stp;
            logic [63:0] rs;
            logic [63:0] re;
            n = 0;
            if (phase < PH_PARSE) begin
                lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
                if (c == 8'h00) begin
                    outs[n] = status_beat(STS_BAD_PREFIX);
                    n++;
                    clear_header();
                end else if (lc == unit_text[phase]) begin
                    phase++;
                end else begin
                    phase       = PH_DISCARD;
                    discard_sts = STS_BAD_PREFIX;
                end
            end else if (phase == PH_DISCARD) begin
                if (c == 8'h00) begin
                    outs[n] = status_beat(discard_sts);
                    n++;
                    clear_header();
                end
            end else begin
                cl  = char_class(c);
                stp = parse_step(pst, cl);
                case (stp.act)
                    ACT_PUSH_START:       start_num = start_num * 64'd10 + {60'd0, c[3:0]};
                    ACT_PUSH_STOP:        stop_num  = stop_num * 64'd10 + {60'd0, c[3:0]};
                    ACT_OMIT_START:       start_num = '1;
                    ACT_OMIT_STOP_SUBMIT: stop_num  = '1;
                    default: ;
                endcase
                if (stp.act == ACT_ABORT) begin
                    if (cl == CL_END) begin
                        outs[n] = status_beat(STS_BAD_SYNTAX);
                        n++;
                        clear_header();
                    end else begin
                        phase       = PH_DISCARD;
                        discard_sts = STS_BAD_SYNTAX;
                    end
                end else begin
                    if (stp.act == ACT_SUBMIT || stp.act == ACT_OMIT_STOP_SUBMIT) begin
                        if (resolve_range(rs, re)) begin
                            outs[n] = '0;
                            outs[n].kind        = KIND_RANGE;
                            outs[n].range_start = rs;
                            outs[n].range_stop  = re;
                            outs[n].status      = STS_OK;
                            n++;
                            any_valid = 1'b1;
                        end
                        start_num = '0;
                        stop_num  = '0;
                    end
                    if (cl == CL_END) begin
                        outs[n] = status_beat(any_valid ? STS_OK : STS_NO_RANGE);
                        n++;
                        clear_header();
                    end else begin
                        pst = stp.nxt;
                    end
                end
            end
            if (n > 0) outs[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) pending_results.push_back(outs[i]);
        endfunction

        function void check_beat(logic got_kind, logic [63:0] got_start,
                                 logic [63:0] got_stop, logic [1:0] got_status,
                                 logic got_last);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: kind %0d start %0d stop %0d status %0d",
                       got_kind, got_start, got_stop, got_status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got_kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got_kind);
                errors++;
            end
            if (got_start !== want.range_start) begin
                $error("range_start: expected %0d, got %0d", want.range_start, got_start);
                errors++;
            end
            if (got_stop !== want.range_stop) begin
                $error("range_stop: expected %0d, got %0d", want.range_stop, got_stop);
                errors++;
            end
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                errors++;
            end
            if (got_last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got_last);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [63:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    range_scoreboard sb;
    logic [7:0]      hdr[$];
    int              src_idle_pct;
    int              sink_stall_pct;
    bit              hold_on = 1'b0;
    int              cycle_count = 0;
    event            start_hold;

    http_byte_range_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_http_byte_range_parser: errors");
            $finish;
        end
    end

    // sample at the falling edge, where every signal is settled
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tuser, m_tdata[63:0], m_tdata[127:64], m_tdata[129:128], m_tlast);
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_on)
                m_tready <= 1'b0;
            else
                m_tready <= !(sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct);
        end
    end

    // long receiver hold-off so the output queue fills and backs up the input
    initial begin
        @(start_hold);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        sb.note_byte(b);
        @(posedge aclk);
    endtask

    task automatic send_header();
        foreach (hdr[i]) send_byte(hdr[i]);
        hdr.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_file_size(input logic [63:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.file_size = v;
    endtask

    function automatic void put_text(string t);
        foreach (t[i]) hdr.push_back(t[i]);
    endfunction

    function automatic void maybe_white();
        logic [7:0] ws[6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
        if ($urandom_range(0, 3) == 0) hdr.push_back(ws[$urandom_range(0, 5)]);
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] fs = sb.file_size;
        logic [63:0] r  = {$urandom, $urandom};
        case ($urandom_range(0, 8))
            0: return 64'd0;
            1: return 64'($urandom_range(0, 99));
            2: return fs - 1;
            3: return fs;
            4: return fs + 1;
            5: return r;
            6: return '1;
            default: return (fs == '1) ? r : r % (fs + 1);
        endcase
    endfunction

    function automatic void put_number();
        int len;
        case ($urandom_range(0, 9))
            0: begin
                // 20 to 24 digits, mostly long enough to wrap the accumulator
                len = $urandom_range(20, 24);
                hdr.push_back(8'(8'h31 + $urandom_range(0, 8)));
                for (int i = 1; i < len; i++) hdr.push_back(8'(8'h30 + $urandom_range(0, 9)));
            end
            1: put_text($sformatf("00%0d", pick_value()));
            default: put_text($sformatf("%0d", pick_value()));
        endcase
    endfunction

    function automatic void put_range();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        case ($urandom_range(0, 9))
            0, 1: begin
                put_number();
                maybe_white();
                put_text("-");
                maybe_white();
                put_number();
            end
            2, 3, 4: begin
                a = pick_value();
                b = pick_value();
                if (a > b && $urandom_range(0, 3) != 0) begin
                    t = a;
                    a = b;
                    b = t;
                end
                put_text($sformatf("%0d", a));
                maybe_white();
                put_text("-");
                maybe_white();
                put_text($sformatf("%0d", b));
            end
            5, 6: begin
                put_number();
                put_text("-");
            end
            7, 8: begin
                put_text("-");
                put_number();
            end
            default: put_text("-");
        endcase
    endfunction

    function automatic void build_header();
        string      unit = "bytes=";
        logic [7:0] ch;
        int         sel;
        int         nr;
        int         k;
        sel = $urandom_range(0, 19);
        hdr.delete();
        if (sel < 2) begin
            nr = $urandom_range(1, 10);
            for (int i = 0; i < nr; i++) hdr.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 4) begin
            // prefix cut short, then optional junk before the end byte
            k = $urandom_range(0, 5);
            for (int i = 0; i < k; i++) hdr.push_back(unit[i]);
            if ($urandom_range(0, 1)) begin
                nr = $urandom_range(1, 4);
                for (int i = 0; i < nr; i++) hdr.push_back(8'($urandom_range(1, 255)));
            end
        end else begin
            foreach (unit[i]) begin
                ch = unit[i];
                if (ch >= 8'h61 && $urandom_range(0, 1)) ch = ch - 8'h20;
                hdr.push_back(ch);
            end
            if (sel > 4) begin
                nr = $urandom_range(1, 4);
                for (int i = 0; i < nr; i++) begin
                    if (i > 0) put_text(",");
                    maybe_white();
                    put_range();
                    maybe_white();
                end
                if ($urandom_range(0, 5) == 0) put_text(",");
            end
        end
        hdr.push_back(8'h00);
        if (sel >= 5 && sel <= 7) hdr[$urandom_range(0, hdr.size() - 2)] = 8'($urandom_range(1, 255));
    endfunction

    initial begin
        logic [63:0] phase_sizes[6];
        int          sent;
        sb             = new();
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        phase_sizes = '{64'd0, 64'd1, 64'd1000, {$urandom, $urandom}, '1,
                        64'h8000_0000_0000_0000};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: upper-case prefix, open and suffix ranges, bad prefix,
        // end byte inside the prefix, bad syntax
        write_file_size(64'd100);
        put_text("BYTES=0-,-5");
        hdr.push_back(8'h00);
        put_text("x");
        hdr.push_back(8'h00);
        hdr.push_back(8'h00);
        put_text("bytes=1x");
        hdr.push_back(8'h00);
        send_header();
        drain();

        for (int p = 0; p < 6; p++) begin
            write_file_size(phase_sizes[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 35; sink_stall_pct = 35; end
            endcase
            if (p == 4) ->start_hold;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_header();
                sent += hdr.size();
                send_header();
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("tb_http_byte_range_parser: clean");
        else
            $display("tb_http_byte_range_parser: errors");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/brp_pkg.sv
hw/rtl/brp_parser.sv
hw/rtl/brp_result_fifo.sv
hw/rtl/http_byte_range_parser.sv
hw/rtl/brp_checker.sv
tb/tb_http_byte_range_parser.sv
